// ===== sv/skt_pkg.sv =====
// Shared types and codes for the sorted key table.
// No dependencies; compile first.
package skt_pkg;

  // Fixed field widths of the request and response transfers
  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [KEY_W-1:0]    key_field_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  // Response status codes
  localparam status_t STS_DONE = 2'd0;
  localparam status_t STS_DUP  = 2'd1;
  localparam status_t STS_MISS = 2'd2;
  localparam status_t STS_FULL = 2'd3;

endpackage

// ===== sv/skt_req_if.sv =====
// Request channel of the sorted key table: valid/ready plus op, key, handle.
// Depends on skt_pkg.
interface skt_req_if;
  import skt_pkg::*;

  logic       valid;
  logic       ready;
  op_t        op;
  key_field_t key;
  handle_t    handle;

  modport source (output valid, output op, output key, output handle, input ready);
  modport sink   (input valid, input op, input key, input handle, output ready);
endinterface

// ===== sv/skt_rsp_if.sv =====
// Response channel of the sorted key table: valid/ready plus status, handle.
// Depends on skt_pkg.
interface skt_rsp_if;
  import skt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  handle_t found_handle;

  modport source (output valid, output status, output found_handle, input ready);
  modport sink   (input valid, input status, input found_handle, output ready);
endinterface

// ===== sv/skt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sorted_key_table_unit.sv =====
// Sorted key table: ordered insert, lookup and remove over a RAM of entries.
// Depends on skt_pkg, skt_req_if, skt_rsp_if and skt_ram.
//
//   port    dir  modport  payload
//   req_i   in   sink     op, key, handle
//   rsp_o   out  source   status, found_handle
//
// One request at a time. A linear scan reads one entry per cycle through the
// RAM read port until the first key not below the request key or the table end.
// An insert then moves entries pos..count-1 up one slot and a remove moves
// entries above pos down one slot, one entry per cycle (RAM read and write port
// in parallel). Reset empties the table at once (count only; no RAM clearing
// pass). The result sits in an output register; a stalled response only holds
// the next request at its final step.
module sorted_key_table_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  skt_req_if.sink    req_i,
  skt_rsp_if.source  rsp_o
);
  import skt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = KEY_BITS + HANDLE_W;
  localparam logic [CW-1:0] DEPTH_W = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_W   = CW'(1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       rd_q, rd_d;
  logic [CW-1:0]       ci_q, ci_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic                cv_q, cv_d;
  logic                iss_q, iss_d;
  logic                ov_q, ov_d;
  op_t                 op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  handle_t             hdl_q, hdl_d;
  status_t             res_st_q, res_st_d;
  handle_t             res_fh_q, res_fh_d;
  status_t             ost_q, ost_d;
  handle_t             ofh_q, ofh_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [RW-1:0]       ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  handle_t             rd_hdl;
  logic [31:0]         key_wide;
  logic [CW-1:0]       pos_n;
  logic [CW-1:0]       wa_up, wa_dn;
  logic                stop, hit_n;

  assign key_wide = 32'(req_i.key);
  assign rd_key   = ram_rdata[RW-1:HANDLE_W];
  assign rd_hdl   = ram_rdata[HANDLE_W-1:0];
  assign wa_up    = ci_q + ONE_W;
  assign wa_dn    = ci_q - ONE_W;

  skt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer and datapath control
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    ci_d      = ci_q;
    pos_d     = pos_q;
    cv_d      = cv_q;
    iss_d     = iss_q;
    op_d      = op_q;
    key_d     = key_q;
    hdl_d     = hdl_q;
    res_st_d  = res_st_q;
    res_fh_d  = res_fh_q;
    ost_d     = ost_q;
    ofh_d     = ofh_q;
    ov_d      = ov_q && !rsp_o.ready;
    ram_re    = 1'b0;
    ram_raddr = rd_q[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = pos_q[AW-1:0];
    ram_wdata = {key_q, hdl_q};
    stop      = 1'b0;
    hit_n     = 1'b0;
    pos_n     = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.op;
          key_d   = key_wide[KEY_BITS-1:0];
          hdl_d   = req_i.handle;
          rd_d    = '0;
          cv_d    = 1'b0;
          state_d = S_SCAN;
        end
      end

      // Linear search for the first entry whose key is not below the request
      S_SCAN: begin
        ram_re = (rd_q < cnt_q);
        cv_d   = ram_re;
        ci_d   = rd_q;
        if (ram_re) begin
          rd_d = rd_q + ONE_W;
        end
        if (cv_q && (rd_key >= key_q)) begin
          stop  = 1'b1;
          pos_n = ci_q;
          hit_n = (rd_key == key_q);
        end else if (!cv_q && !ram_re) begin
          stop  = 1'b1;
          pos_n = cnt_q;
        end
        if (stop) begin
          pos_d    = pos_n;
          cv_d     = 1'b0;
          res_st_d = STS_MISS;
          res_fh_d = '0;
          state_d  = S_FIN;
          case (op_q)
            OP_INSERT: begin
              if (hit_n) begin
                res_st_d = STS_DUP;
              end else if (cnt_q == DEPTH_W) begin
                res_st_d = STS_FULL;
              end else if (pos_n == cnt_q) begin
                state_d = S_PUT;
              end else begin
                rd_d    = cnt_q - ONE_W;
                iss_d   = 1'b1;
                state_d = S_SHUP;
              end
            end
            OP_LOOKUP: begin
              if (hit_n) begin
                res_st_d = STS_DONE;
                res_fh_d = rd_hdl;
              end
            end
            OP_REMOVE: begin
              if (hit_n) begin
                res_st_d = STS_DONE;
                res_fh_d = rd_hdl;
                if (pos_n + ONE_W == cnt_q) begin
                  cnt_d = cnt_q - ONE_W;
                end else begin
                  rd_d    = pos_n + ONE_W;
                  iss_d   = 1'b1;
                  state_d = S_SHDN;
                end
              end
            end
            default: begin
              res_st_d = STS_MISS;
            end
          endcase
        end
      end

      // Move entries pos..count-1 up one slot, top entry first
      S_SHUP: begin
        ram_re = iss_q;
        cv_d   = iss_q;
        ci_d   = rd_q;
        if (iss_q) begin
          if (rd_q == pos_q) begin
            iss_d = 1'b0;
          end else begin
            rd_d = rd_q - ONE_W;
          end
        end
        if (cv_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_up[AW-1:0];
          ram_wdata = ram_rdata;
          if (!iss_q) begin
            state_d = S_PUT;
          end
        end
      end

      // Write the new entry into the opened slot
      S_PUT: begin
        ram_we   = 1'b1;
        cnt_d    = cnt_q + ONE_W;
        res_st_d = STS_DONE;
        res_fh_d = '0;
        state_d  = S_FIN;
      end

      // Move entries pos+1..count-1 down one slot, lowest entry first
      S_SHDN: begin
        ram_re = iss_q;
        cv_d   = iss_q;
        ci_d   = rd_q;
        if (iss_q) begin
          if (rd_q == cnt_q - ONE_W) begin
            iss_d = 1'b0;
          end else begin
            rd_d = rd_q + ONE_W;
          end
        end
        if (cv_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_dn[AW-1:0];
          ram_wdata = ram_rdata;
          if (!iss_q) begin
            cnt_d   = cnt_q - ONE_W;
            state_d = S_FIN;
          end
        end
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          ost_d   = res_st_q;
          ofh_d   = res_fh_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cv_q    <= 1'b0;
      iss_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cv_q    <= cv_d;
      iss_q   <= iss_d;
      ov_q    <= ov_d;
    end
  end

  // Payload and index registers
  always_ff @(posedge clk_i) begin
    rd_q     <= rd_d;
    ci_q     <= ci_d;
    pos_q    <= pos_d;
    op_q     <= op_d;
    key_q    <= key_d;
    hdl_q    <= hdl_d;
    res_st_q <= res_st_d;
    res_fh_q <= res_fh_d;
    ost_q    <= ost_d;
    ofh_q    <= ofh_d;
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.found_handle = ofh_q;

`ifndef SYNTH
  // Entry count never exceeds the table depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_W)
    else $error("entry count above table depth");

  // The table is never written while idle or searching
  a_no_write_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_SCAN) |-> !ram_we)
    else $error("table write outside a shift or put step");

  // Duplicate and full only come back for an insert
  a_dup_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (res_st_q == STS_DUP || res_st_q == STS_FULL))
      |-> op_q == OP_INSERT)
    else $error("duplicate or full status for a non-insert");

  // A completed insert grows the table by exactly one entry
  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |=> cnt_q == $past(cnt_q) + ONE_W)
    else $error("insert did not grow the table by one");
`endif

endmodule

// ===== tb/tb_sorted_key_table_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_table_unit: directed and random insert, lookup
// and remove traffic against a behavioral copy of the ordered table.
// Depends on skt_pkg, skt_req_if, skt_rsp_if and the RTL of the block.
module tb_sorted_key_table_unit;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 16;
  localparam key_field_t KEY_MASK = key_field_t'((64'd1 << KEY_BITS) - 64'd1);
  // op code the block must ignore
  localparam op_t OP_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned SETTLE_TICKS = 40;

  typedef struct packed {
    status_t status;
    handle_t found_handle;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  skt_req_if req_if ();
  skt_rsp_if rsp_if ();

  sorted_key_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Expected table contents, kept in ascending key order
  key_field_t    table_keys[TABLE_DEPTH];
  handle_t       table_handles[TABLE_DEPTH];
  int unsigned   table_count;
  table_result_t pending_results[$];
  table_result_t oldest_result;
  int unsigned   fail_count;
  int unsigned   burst_left;
  int unsigned   quiet_cycles = 0;
  logic [7:0]    ready_phase = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one operation to the expected table and return its response
  function automatic table_result_t apply_table_op(op_t op, key_field_t key_in,
                                                   handle_t handle);
    key_field_t    key;
    int unsigned   pos;
    logic          hit;
    table_result_t res;
    key              = key_in & KEY_MASK;
    res.status       = STS_MISS;
    res.found_handle = '0;
    pos = 0;
    while (pos < table_count && table_keys[pos] < key) pos++;
    hit = (pos < table_count) && (table_keys[pos] == key);
    case (op)
      OP_INSERT: begin
        if (hit) begin
          res.status = STS_DUP;
        end else if (table_count >= TABLE_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          for (int unsigned i = table_count; i > pos; i--) begin
            table_keys[i]    = table_keys[i-1];
            table_handles[i] = table_handles[i-1];
          end
          table_keys[pos]    = key;
          table_handles[pos] = handle;
          table_count++;
          res.status = STS_DONE;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res.status       = STS_DONE;
          res.found_handle = table_handles[pos];
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          res.status       = STS_DONE;
          res.found_handle = table_handles[pos];
          for (int unsigned i = pos; i + 1 < table_count; i++) begin
            table_keys[i]    = table_keys[i+1];
            table_handles[i] = table_handles[i+1];
          end
          table_count--;
        end
      end
      default: ;  // unused code leaves the table alone
    endcase
    return res;
  endfunction

  // Send one request in bursts with random gaps; predict once it is transferred
  task automatic send_item(op_t op, key_field_t key, handle_t handle);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid  <= 1'b1;
    req_if.op     <= op;
    req_if.key    <= key;
    req_if.handle <= handle;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_results.push_back(apply_table_op(op, key, handle));
  endtask

  // Stop sending and wait until every pending response has arrived
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_table();
    send_item(OP_LOOKUP, 16'h0000, 32'h0000_0000);
    send_item(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
    hold_until_drained();
  endtask

  task automatic test_key_extremes();
    send_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 16'h0000, 32'h0000_0000);
    send_item(OP_INSERT, 16'h7FFF, 32'hA5A5_A5A5);
    send_item(OP_INSERT, 16'hFFFF, 32'h1234_5678);  // duplicate, handle kept
    send_item(OP_LOOKUP, 16'hFFFF, 32'h0000_0000);
    send_item(OP_REMOVE, 16'h7FFF, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 16'h0000, 32'h0000_0000);  // first entry
    hold_until_drained();
  endtask

  task automatic test_unused_op();
    send_item(OP_UNUSED, 16'hFFFF, 32'hDEAD_BEEF);
    send_item(OP_LOOKUP, 16'hFFFF, 32'h0000_0000);
    hold_until_drained();
  endtask

  task automatic test_full_table();
    // descending keys so every insert shifts the whole table
    for (int i = 14; i >= 0; i--) begin
      send_item(OP_INSERT, key_field_t'(16'h1000 * i + 16'h0800), handle_t'($urandom));
    end
    send_item(OP_INSERT, 16'h0001, 32'h5555_AAAA);  // full, new key
    send_item(OP_INSERT, 16'h7800, 32'hAAAA_5555);  // full, duplicate wins
    send_item(OP_REMOVE, 16'h7800, 32'h0000_0000);
    send_item(OP_INSERT, 16'h0001, 32'h5555_AAAA);
    send_item(OP_LOOKUP, 16'h0001, 32'h0000_0000);
    hold_until_drained();
  endtask

  // Phases with a small key pool so most requests hit; insert bias varies per phase
  task automatic test_random_traffic(int unsigned item_total);
    key_field_t  key_pool[$];
    int unsigned pick;
    int unsigned insert_weight;
    op_t         op;
    key_field_t  key;
    for (int unsigned n = 0; n < item_total; n++) begin
      if (n % 50 == 0) begin
        key_pool.delete();
        repeat ($urandom_range(4, 24)) key_pool.push_back(key_field_t'($urandom));
        if ($urandom_range(0, 2) == 0) key_pool.push_back('1);
        if ($urandom_range(0, 2) == 0) key_pool.push_back('0);
        insert_weight = $urandom_range(20, 70);
      end
      if (n == item_total / 2) hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) begin
        op = OP_INSERT;
      end else if (pick < insert_weight + (100 - insert_weight) / 2) begin
        op = OP_REMOVE;
      end else if (pick < 96) begin
        op = OP_LOOKUP;
      end else begin
        op = OP_UNUSED;
      end
      if ($urandom_range(0, 4) == 0) begin
        key = key_field_t'($urandom);
      end else begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      send_item(op, key, handle_t'($urandom));
    end
    hold_until_drained();
  endtask

  // Response ready: always ready, random, one in four, then mostly ready
  always @(posedge clk_i) begin
    ready_phase <= ready_phase + 8'd1;
    case (ready_phase[7:6])
      2'd0:    rsp_if.ready <= 1'b1;
      2'd1:    rsp_if.ready <= 1'($urandom_range(0, 1));
      2'd2:    rsp_if.ready <= (ready_phase[1:0] == 2'd0);
      default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare each response transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: response with none pending: expected nothing, actual %0d 0x%08h",
                 $time, rsp_if.status, rsp_if.found_handle);
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_if.status !== oldest_result.status) begin
          fail_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, oldest_result.status, rsp_if.status);
        end
        if (rsp_if.found_handle !== oldest_result.found_handle) begin
          fail_count++;
          $display("%0t: found_handle mismatch: expected 0x%08h, actual 0x%08h",
                   $time, oldest_result.found_handle, rsp_if.found_handle);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.op     <= OP_INSERT;
    req_if.key    <= '0;
    req_if.handle <= '0;
    table_count = 0;
    fail_count  = 0;
    burst_left  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_key_extremes();
    test_unused_op();
    test_full_table();
    test_random_traffic(750);

    hold_until_drained();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t: %0d responses never arrived", $time, pending_results.size());
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
